// ----- sv/color_contrast_target_accumulate_top_defines.svh -----
// Assertion macros for the contrast accumulator.
`ifndef COLOR_CONTRAST_TARGET_ACCUMULATE_TOP_DEFINES_SVH
`define COLOR_CONTRAST_TARGET_ACCUMULATE_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define CCTA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ccta assertion failed");

// Next-cycle implication.
`define CCTA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ccta assertion failed");

`endif

// ----- sv/ccta_pkg.sv -----
// Types and constants of the contrast accumulator.
package ccta_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_COS   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SIN   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_ALPHA = 2'd2;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [31:0] INV6    = 32'd43691;  // 2^18 / 6, rounded up
  localparam logic [16:0] T_ONE   = 17'h1_0000;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL_DA,
    ST_MUL_DB,
    ST_SQ_SUM,
    ST_SQRT,
    ST_CHK,
    ST_DIV_X,
    ST_MUL_ZZ,
    ST_MUL_Z3,
    ST_MUL_D6,
    ST_EPOLY,
    ST_SQR_MUL,
    ST_SQR_RND,
    ST_T_INIT,
    ST_DIV_T,
    ST_MUL_DC,
    ST_MUL_COS,
    ST_MUL_SIN,
    ST_SELECT,
    ST_MUL_W,
    ST_ACCUM
  } state_e;

endpackage

// ----- sv/color_contrast_target_accumulate_top.sv -----
// The next input is taken only when the sequencer is idle, so one item is processed at a time.
// The cost is set by one shared 32x32 multiplier, which also runs the ten squarings, and one
// shift-subtract unit that runs the 17-step square root and the 19-step and 17-step divisions
// serially.
// Reset (rst_ni low, asynchronous) clears the sum, the clip flag and the output valid and
// loads cos_theta = 1.0, sin_theta = 0 and alpha = 10.0.
module color_contrast_target_accumulate_top #(
  parameter int unsigned MAX_WEIGHT = 1048576
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ccta_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [15:0]                     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [14:0]                     pixel_l_i,
  input  logic signed [15:0]              pixel_a_i,
  input  logic signed [15:0]              pixel_b_i,
  input  logic [14:0]                     ref_l_i,
  input  logic signed [15:0]              ref_a_i,
  input  logic signed [15:0]              ref_b_i,
  input  logic [20:0]                     weight_i,
  input  logic                            last_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [35:0]              target_diff_o,
  output logic                            saturated_o
);
  import ccta_pkg::*;

  `include "color_contrast_target_accumulate_top_defines.svh"

  state_e state_q, state_d;

  logic signed [15:0] cos_q, sin_q;
  logic [14:0]        alpha_q;

  logic signed [15:0] dl_q, dl_d;
  logic signed [16:0] da_q, da_d, db_q, db_d;
  logic [20:0]        w_q, w_d;
  logic               last_q, last_d;

  logic [33:0] sq_q, sq_d;
  logic [47:0] rem_q, rem_d;
  logic [18:0] quo_q, quo_d;
  logic [31:0] den_q, den_d;
  logic [46:0] num_q, num_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [23:0] z_q, z_d;
  logic [17:0] z2_q, z2_d;
  logic [30:0] e_q, e_d;
  logic [14:0] dc_q, dc_d;
  logic signed [33:0] proj_q, proj_d;
  logic signed [15:0] delta_q, delta_d;

  logic signed [35:0] sum_q, sum_d;
  logic               clip_q, clip_d;
  logic               out_valid_q, out_valid_d;
  logic signed [35:0] out_sum_q, out_sum_d;
  logic               out_sat_q, out_sat_d;

  // shared multiplier
  logic               mul_en;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_q;

  // shared shift-subtract unit
  logic [1:0]  sq_pair;
  logic        num_bit;
  logic [47:0] rem_sh, cs_b;
  logic [48:0] diff;
  logic        ge;

  logic        in_xfer;
  logic        acc_hold;
  logic [11:0] z3;
  logic [15:0] absl;
  logic signed [33:0] proj;
  logic signed [37:0] sum_ext;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign acc_hold   = last_q && out_valid_q && out_stall_i;

  assign sq_pair = 2'(sq_q >> {cnt_q, 1'b0});
  assign num_bit = 1'(num_q >> cnt_q);
  assign rem_sh  = (state_q == ST_SQRT) ? {rem_q[45:0], sq_pair} : {rem_q[46:0], num_bit};
  assign cs_b    = (state_q == ST_SQRT) ? {29'b0, quo_q[16:0], 2'b01} : {16'b0, den_q};
  assign diff    = {1'b0, rem_sh} - {1'b0, cs_b};
  assign ge      = !diff[48];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_xfer) state_d = ST_MUL_DA;
      ST_MUL_DA:  state_d = ST_MUL_DB;
      ST_MUL_DB:  state_d = ST_SQ_SUM;
      ST_SQ_SUM:  state_d = ST_SQRT;
      ST_SQRT:    if (cnt_q == 5'd0) state_d = ST_CHK;
      ST_CHK: begin
        if ({1'b0, quo_q[16:0]} >= {alpha_q, 3'b000}) state_d = ST_MUL_DC;
        else state_d = ST_DIV_X;
      end
      ST_DIV_X:   if (cnt_q == 5'd0) state_d = ST_MUL_ZZ;
      ST_MUL_ZZ:  state_d = ST_MUL_Z3;
      ST_MUL_Z3:  state_d = ST_MUL_D6;
      ST_MUL_D6:  state_d = ST_EPOLY;
      ST_EPOLY:   state_d = ST_SQR_MUL;
      ST_SQR_MUL: state_d = ST_SQR_RND;
      ST_SQR_RND: state_d = (cnt_q == 5'd0) ? ST_T_INIT : ST_SQR_MUL;
      ST_T_INIT:  state_d = ST_DIV_T;
      ST_DIV_T:   if (cnt_q == 5'd0) state_d = ST_MUL_DC;
      ST_MUL_DC:  state_d = ST_MUL_COS;
      ST_MUL_COS: state_d = ST_MUL_SIN;
      ST_MUL_SIN: state_d = ST_SELECT;
      ST_SELECT:  state_d = ST_MUL_W;
      ST_MUL_W:   state_d = ST_ACCUM;
      ST_ACCUM:   if (!acc_hold) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    dl_d = dl_q; da_d = da_q; db_d = db_q; w_d = w_q; last_d = last_q;
    sq_d = sq_q; rem_d = rem_q; quo_d = quo_q; den_d = den_q; num_d = num_q;
    cnt_d = cnt_q; z_d = z_q; z2_d = z2_q; e_d = e_q; dc_d = dc_q;
    proj_d = proj_q; delta_d = delta_q;
    sum_d = sum_q; clip_d = clip_q;
    out_sum_d = out_sum_q; out_sat_d = out_sat_q;
    out_valid_d = out_valid_q && out_stall_i;
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    z3      = 12'(mul_q >>> 30);
    absl    = dl_q[15] ? 16'(-dl_q) : 16'(dl_q);
    proj    = proj_q + mul_q[33:0];
    sum_ext = 38'(sum_q) + mul_q[37:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          dl_d   = $signed({1'b0, pixel_l_i}) - $signed({1'b0, ref_l_i});
          da_d   = 17'(pixel_a_i) - 17'(ref_a_i);
          db_d   = 17'(pixel_b_i) - 17'(ref_b_i);
          w_d    = (32'(weight_i) > 32'(MAX_WEIGHT)) ? 21'(MAX_WEIGHT) : weight_i;
          last_d = last_i;
        end
      end
      ST_MUL_DA: begin
        mul_en = 1'b1;
        mul_a  = 32'(da_q);
        mul_b  = 32'(da_q);
      end
      ST_MUL_DB: begin
        sq_d   = mul_q[33:0];
        mul_en = 1'b1;
        mul_a  = 32'(db_q);
        mul_b  = 32'(db_q);
      end
      ST_SQ_SUM: begin
        sq_d  = sq_q + mul_q[33:0];
        rem_d = '0;
        quo_d = '0;
        cnt_d = 5'd16;
      end
      ST_SQRT, ST_DIV_X, ST_DIV_T: begin
        rem_d = ge ? diff[47:0] : rem_sh;
        quo_d = {quo_q[17:0], ge};
        cnt_d = cnt_q - 5'd1;
      end
      ST_CHK: begin
        if ({1'b0, quo_q[16:0]} >= {alpha_q, 3'b000}) begin
          quo_d = 19'(T_ONE);  // tanh saturates to one
        end else begin
          rem_d = 48'(quo_q[16:3]);
          num_d = 47'({quo_q[16:0], 16'b0});
          den_d = 32'(alpha_q);
          quo_d = '0;
          cnt_d = 5'd18;
        end
      end
      ST_MUL_ZZ: begin
        z_d    = {quo_q, 5'b0};
        mul_en = 1'b1;
        mul_a  = $signed(32'(z_d));
        mul_b  = $signed(32'(z_d));
      end
      ST_MUL_Z3: begin
        z2_d   = 18'(mul_q >>> 30);
        mul_en = 1'b1;
        mul_a  = $signed(32'(z2_d));
        mul_b  = $signed(32'(z_q));
      end
      ST_MUL_D6: begin
        mul_en = 1'b1;
        mul_a  = $signed(32'(z3));
        mul_b  = $signed(INV6);
      end
      ST_EPOLY: begin
        e_d   = 31'(33'(Q30_ONE) - 33'(z_q) + 33'(z2_q >> 1) - 33'(mul_q[27:18]));
        cnt_d = 5'd9;
      end
      ST_SQR_MUL: begin
        mul_en = 1'b1;
        mul_a  = $signed(32'(e_q));
        mul_b  = $signed(32'(e_q));
      end
      ST_SQR_RND: begin
        e_d = 31'((mul_q[60:0] + 61'h2000_0000) >> 30);
        if (cnt_q != 5'd0) cnt_d = cnt_q - 5'd1;
      end
      ST_T_INIT: begin
        den_d = 32'(Q30_ONE) + 32'(e_q);
        num_d = 47'({Q30_ONE - e_q, 16'b0}) + 47'(den_d >> 1);
        rem_d = 48'(num_d >> 17);
        quo_d = '0;
        cnt_d = 5'd16;
      end
      ST_MUL_DC: begin
        mul_en = 1'b1;
        mul_a  = $signed(32'(alpha_q));
        mul_b  = $signed(32'(quo_q[16:0]));
      end
      ST_MUL_COS: begin
        dc_d   = 15'((mul_q[32:0] + 33'h8000) >> 16);
        mul_en = 1'b1;
        mul_a  = 32'(cos_q);
        mul_b  = 32'(da_q);
      end
      ST_MUL_SIN: begin
        proj_d = mul_q[33:0];
        mul_en = 1'b1;
        mul_a  = 32'(sin_q);
        mul_b  = 32'(db_q);
      end
      ST_SELECT: begin
        if (absl > {1'b0, dc_q}) delta_d = dl_q;
        else if (proj > 34'sd0) delta_d = $signed({1'b0, dc_q});
        else delta_d = -$signed({1'b0, dc_q});
      end
      ST_MUL_W: begin
        mul_en = 1'b1;
        mul_a  = 32'(delta_q);
        mul_b  = $signed(32'(w_q));
      end
      ST_ACCUM: begin
        if (!acc_hold) begin
          if (sum_ext > 38'sh07_FFFF_FFFF) begin
            sum_d  = 36'sh7_FFFF_FFFF;
            clip_d = 1'b1;
          end else if (sum_ext < -38'sh08_0000_0000) begin
            sum_d  = -36'sh8_0000_0000;
            clip_d = 1'b1;
          end else begin
            sum_d = 36'(sum_ext);
          end
          if (last_q) begin
            out_sum_d   = sum_d;
            out_sat_d   = clip_d;
            out_valid_d = 1'b1;
            sum_d       = '0;
            clip_d      = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cos_q       <= 16'sd16384;
      sin_q       <= 16'sd0;
      alpha_q     <= 15'd2560;
      sum_q       <= '0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      clip_q      <= clip_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_COS:   cos_q   <= cfg_data_i;
          REG_SIN:   sin_q   <= cfg_data_i;
          REG_ALPHA: alpha_q <= cfg_data_i[14:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dl_q <= dl_d; da_q <= da_d; db_q <= db_d; w_q <= w_d; last_q <= last_d;
    sq_q <= sq_d; rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d; num_q <= num_d;
    z_q <= z_d; z2_q <= z2_d; e_q <= e_d; dc_q <= dc_d;
    proj_q <= proj_d; delta_q <= delta_d;
    out_sum_q <= out_sum_d; out_sat_q <= out_sat_d;
    if (mul_en) mul_q <= mul_a * mul_b;
  end

  assign out_valid_o   = out_valid_q;
  assign target_diff_o = out_sum_q;
  assign saturated_o   = out_sat_q;

  `CCTA_ASSERT_NXT(a_accept_starts, in_xfer, state_q == ST_MUL_DA)
  `CCTA_ASSERT_IMP(a_result_from_accum, $rose(out_valid_q),
                   $past(state_q) == ST_ACCUM && $past(last_q))
  `CCTA_ASSERT_NXT(a_clear_on_last, state_q == ST_ACCUM && last_q && !acc_hold,
                   sum_q == '0 && !clip_q)
  `CCTA_ASSERT_IMP(a_exp_bounded, state_q == ST_SQR_MUL, e_q <= Q30_ONE)

endmodule
